// ----- hdl/ilid_pkg.sv -----
// Package: request/result types and codes for the indexed list block.
`timescale 1ns / 1ps
package ilid_pkg;

    localparam logic [2:0] OP_GET      = 3'd0;
    localparam logic [2:0] OP_INS_HEAD = 3'd1;
    localparam logic [2:0] OP_INS_TAIL = 3'd2;
    localparam logic [2:0] OP_INS_POS  = 3'd3;
    localparam logic [2:0] OP_DEL_POS  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        MODE_HOLD = 3'b001,
        MODE_INS  = 3'b010,
        MODE_DEL  = 3'b100
    } t_mode;

    typedef struct packed {
        logic        [2:0]  op;
        logic        [6:0]  position;
        logic signed [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic        [1:0]  status;
        logic        [6:0]  list_length;
    } t_res;

endpackage

// ----- hdl/indexed_list_insert_delete.sv -----
// Top level: ordered list held in a row of shifting register cells.
//
//  channel | ports                    | handshake
//  --------+--------------------------+---------------------------------
//  request | start, busy, i_req       | taken when start high, busy low
//  result  | o_strobe, o_result       | one-cycle strobe, cannot stall
//
// One request per cycle; its result strobes the cycle after acceptance.
// Insert loads the target cell and shifts those above it up a place;
// delete shifts it and those above down at once. busy is never raised.
// Reset clears the entry count and strobe; cell contents stay undefined
// until written. The receiver cannot stall results.
`timescale 1ns / 1ps
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CW > 7) ? CW : 7;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_strobe;
    t_res          r_result;
    t_res          n_result;

    t_mode              mode;
    logic [AW-1:0]      at;
    logic [AW-1:0]      pos_ext;
    logic [AW-1:0]      cnt_ext;
    logic               full;
    logic               accept;
    logic signed [31:0] rd_value;
    logic signed [31:0] w_value [CAPACITY];

    assign accept  = start & ~busy;
    assign busy    = 1'b0;
    assign pos_ext = AW'(i_req.position);
    assign cnt_ext = AW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (pos_ext == AW'(k)) begin
                rd_value = rd_value | w_value[k];
            end
        end
    end

    always_comb begin
        mode     = MODE_HOLD;
        at       = pos_ext;
        n_count  = r_count;
        n_result = '{read_value: 32'sd0, found: 1'b0, status: ST_DONE,
                     list_length: 7'd0};
        case (i_req.op)
            OP_GET: begin
                if (pos_ext < cnt_ext) begin
                    n_result.read_value = rd_value;
                    n_result.found      = 1'b1;
                end else begin
                    n_result.read_value = -32'sd1;
                    n_result.status     = ST_RANGE;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (i_req.op == OP_INS_HEAD) begin
                    at = '0;
                end else if (i_req.op == OP_INS_TAIL) begin
                    at = cnt_ext;
                end
                if (at > cnt_ext) begin
                    n_result.status = ST_RANGE;
                end else if (full) begin
                    n_result.status = ST_FULL;
                end else begin
                    mode    = MODE_INS;
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEL_POS: begin
                if (pos_ext < cnt_ext) begin
                    mode    = MODE_DEL;
                    n_count = r_count - CW'(1);
                end else begin
                    n_result.status = ST_RANGE;
                end
            end
            default: n_result.status = ST_RANGE;
        endcase
        n_result.list_length = 7'(n_count);
        if (!accept) begin
            mode    = MODE_HOLD;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ilid_cell #(
            .AW    (AW),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (mode),
            .i_at    (at),
            .i_prev  (w_value[(g == 0) ? 0 : g - 1]),
            .i_next  (w_value[(g == CAPACITY - 1) ? g : g + 1]),
            .i_new   (i_req.item_value),
            .o_value (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("request not answered in the next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.found |-> o_result.status == ST_DONE)
        else $error("found with non-done status");

    a_ignored_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_result.status != ST_DONE |=> r_count == $past(r_count))
        else $error("ignored request changed the length");

endmodule

// ----- hdl/ilid_cell.sv -----
// One list entry: holds, loads, or takes a neighbour's value on a shift.
`timescale 1ns / 1ps
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int AW    = 7,
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  t_mode                i_mode,
    input  logic        [AW-1:0] i_at,
    input  logic signed [31:0]   i_prev,
    input  logic signed [31:0]   i_next,
    input  logic signed [31:0]   i_new,
    output logic signed [31:0]   o_value
);

    localparam logic [AW-1:0] MyIdx = AW'(INDEX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_mode)
            MODE_INS: begin
                if (MyIdx == i_at) begin
                    n_value = i_new;
                end else if (MyIdx > i_at) begin
                    n_value = i_prev;
                end
            end
            MODE_DEL: begin
                if (MyIdx >= i_at) begin
                    n_value = i_next;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the indexed list block: directed, fill-to-full and random requests.
`timescale 1ns / 1ps
module testbench;
    import ilid_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int QUIET_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_strobe;
    t_res o_result;

    logic signed [31:0] list_cells [0:LIST_DEPTH-1];
    int list_len = 0;
    t_res pending_results [$];
    int errors = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;

    indexed_list_insert_delete #(.CAPACITY(LIST_DEPTH)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_req make_req(input logic [2:0] op, input logic [6:0] pos,
                                      input logic signed [31:0] val);
        t_req r;
        r.op = op;
        r.position = pos;
        r.item_value = val;
        return r;
    endfunction

    function automatic t_res apply_list_op(input t_req r);
        t_res res;
        int at;
        res = '0;
        res.status = ST_DONE;
        case (r.op)
            OP_GET: begin
                if (r.position < list_len) begin
                    res.read_value = list_cells[r.position];
                    res.found = 1'b1;
                end else begin
                    res.read_value = -32'sd1;
                    res.status = ST_RANGE;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (r.op == OP_INS_HEAD) at = 0;
                else if (r.op == OP_INS_TAIL) at = list_len;
                else at = r.position;
                if (at > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > at; k--) list_cells[k] = list_cells[k-1];
                    list_cells[at] = r.item_value;
                    list_len++;
                end
            end
            OP_DEL_POS: begin
                if (r.position < list_len) begin
                    for (int k = r.position; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: res.status = ST_RANGE;
        endcase
        res.list_length = list_len[6:0];
        return res;
    endfunction

    task automatic send_req(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_list_op(r));
        if (idle_on && $urandom_range(0, 99) < 5) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // result check against the oldest pending prediction
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.read_value !== want.read_value || o_result.found !== want.found
                    || o_result.status !== want.status
                    || o_result.list_length !== want.list_length) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected value %0d found %0b status %0d len %0d,",
                            want.read_value, want.found, want.status, want.list_length);
                        $display("          got value %0d found %0b status %0d len %0d",
                            o_result.read_value, o_result.found, o_result.status,
                            o_result.list_length);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_req(make_req(OP_GET, 7'd0, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd0, 32'sd0));
        send_req(make_req(OP_INS_POS, 7'd1, 32'sd5));
        send_req(make_req(OP_INS_POS, 7'd0, 32'sh7FFF_FFFF));
        send_req(make_req(OP_INS_HEAD, 7'd127, 32'sh8000_0000));
        send_req(make_req(OP_INS_TAIL, 7'd0, -32'sd1));
        send_req(make_req(OP_INS_POS, 7'd1, 32'sd0));
        send_req(make_req(OP_INS_POS, 7'd4, 32'sh5A5A_A5A5));
        for (int p = 0; p <= 5; p++) send_req(make_req(OP_GET, p[6:0], 32'sd0));
        send_req(make_req(OP_GET, 7'd127, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd5, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd2, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd127, 32'sd0));
        send_req(make_req(3'd5, 7'd0, 32'sd1));
        send_req(make_req(3'd6, 7'd64, -32'sd1));
        send_req(make_req(3'd7, 7'd127, 32'sh8000_0000));
        send_req(make_req(OP_GET, 7'd2, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd0, 32'sd0));
    endtask

    task automatic test_fill_to_full();
        drain_results();
        while (list_len < LIST_DEPTH) send_req(make_req(OP_INS_TAIL, 7'd0, pick_value()));
        send_req(make_req(OP_INS_HEAD, 7'd0, 32'sd1));
        send_req(make_req(OP_INS_TAIL, 7'd0, 32'sd2));
        send_req(make_req(OP_INS_POS, 7'd64, 32'sd3));
        send_req(make_req(OP_INS_POS, 7'd65, 32'sd4));
        send_req(make_req(OP_GET, 7'd63, 32'sd0));
        send_req(make_req(OP_GET, 7'd64, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd64, 32'sd0));
        send_req(make_req(OP_DEL_POS, 7'd63, 32'sd0));
        send_req(make_req(OP_INS_POS, 7'd63, 32'sh8000_0000));
        send_req(make_req(OP_DEL_POS, 7'd0, 32'sd0));
        send_req(make_req(OP_INS_HEAD, 7'd0, 32'sh7FFF_FFFF));
        drain_results();
        while (list_len > 0)
            send_req(make_req(OP_DEL_POS, 7'($urandom_range(0, list_len - 1)), 32'sd0));
        send_req(make_req(OP_GET, 7'd0, 32'sd0));
    endtask

    task automatic random_burst(input int n_items);
        t_req r;
        int roll;
        bit filling;
        filling = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i % 90 == 89) filling = ~filling;
            roll = $urandom_range(0, 99);
            r = make_req(OP_GET, 7'd0, pick_value());
            if (roll < 6) begin
                r.op = 3'($urandom_range(0, 7));
                r.position = 7'($urandom_range(0, 127));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 30) r.op = OP_GET;
                else if (roll < (filling ? 80 : 45))
                    r.op = 3'(OP_INS_HEAD + $urandom_range(0, 2));
                else r.op = OP_DEL_POS;
                if ($urandom_range(0, 9) == 0)
                    r.position = 7'($urandom_range(list_len, 127));
                else if (r.op == OP_INS_POS)
                    r.position = 7'($urandom_range(0, list_len));
                else
                    r.position = 7'($urandom_range(0, (list_len > 0) ? list_len - 1 : 0));
            end
            send_req(r);
        end
    endtask

    task automatic test_random_idle();
        idle_on = 1'b1;
        random_burst(330);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        random_burst(120);
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_to_full();
        test_random_idle();
        test_back_to_back();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ilid_pkg.sv
hdl/ilid_cell.sv
hdl/indexed_list_insert_delete.sv
sim/testbench.sv
